// ===== rtl/core/wspe_pkg.sv =====
// ----------------------------------------------------------------------------
// wspe_pkg
// Shared types, constants and helper functions for the WS2812 SPI encoder.
// ----------------------------------------------------------------------------
package wspe_pkg;

    localparam int unsigned NUM_BYTES = 12;
    localparam int unsigned CNT_W     = $clog2(NUM_BYTES);
    localparam int unsigned PIX_W     = 24;
    localparam int unsigned IDX_W     = $clog2(PIX_W);

    localparam logic [7:0] SYM_ONE_HI  = 8'hE0;
    localparam logic [7:0] SYM_ZERO_HI = 8'h80;
    localparam logic [7:0] SYM_ONE_LO  = 8'h0E;
    localparam logic [7:0] SYM_ZERO_LO = 8'h08;

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;

    typedef enum logic {
        MODE_DIRECT = 1'b0,
        MODE_WHEEL  = 1'b1
    } mode_t;

    typedef logic [PIX_W-1:0] pixel_t;   // {green, red, blue}

    // Color wheel, returned in G, R, B order.
    function automatic pixel_t wheel_grb(input logic [7:0] p);
        logic [7:0] q;
        logic [7:0] up;
        logic [7:0] dn;
        pixel_t     res;
        priority if (p < WHEEL_SEG1)
        begin
            q = p;
        end
        else if (p < WHEEL_SEG2)
        begin
            q = p - WHEEL_SEG1;
        end
        else
        begin
            q = p - WHEEL_SEG2;
        end
        up = 8'({q, 1'b0} + {1'b0, q});
        dn = ~up;
        priority if (p < WHEEL_SEG1)
        begin
            res = {dn, up, 8'h00};
        end
        else if (p < WHEEL_SEG2)
        begin
            res = {8'h00, dn, up};
        end
        else
        begin
            res = {up, 8'h00, dn};
        end
        return res;
    endfunction

    // Two color bits -> one SPI byte of two 4-bit symbols.
    function automatic logic [7:0] encode_pair(input logic [1:0] bits);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = bits[1] ? SYM_ONE_HI : SYM_ZERO_HI;
        lo = bits[0] ? SYM_ONE_LO : SYM_ZERO_LO;
        return hi | lo;
    endfunction

endpackage

// ===== rtl/core/wspe_ifs.sv =====
// ----------------------------------------------------------------------------
// wspe_ifs
// Valid/ready channels for pixel input and SPI byte output.
// ----------------------------------------------------------------------------
interface wspe_pix_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] wheel_pos;

    modport source (output valid, output mode, output red, output green,
                    output blue, output wheel_pos, input ready);
    modport sink   (input valid, input mode, input red, input green,
                    input blue, input wheel_pos, output ready);
endinterface

interface wspe_spi_if;
    logic       valid;
    logic       ready;
    logic [7:0] spi_byte;
    logic       last;

    modport source (output valid, output spi_byte, output last, input ready);
    modport sink   (input valid, input spi_byte, input last, output ready);
endinterface

// ===== rtl/core/ws2812_spi_pixel_encoder.sv =====
// Each accepted pixel is held in the pixel register; each SPI byte is registered in the output register.
// Throughput: one SPI byte per cycle while the receiver is ready, set by the byte
// counter that walks the held pixel word; the next pixel is taken in the
// cycle its predecessor's last byte moves into the output register.
// Reset (rst_n, async, active low) clears the valid flags and byte counter.
// ----------------------------------------------------------------------------
// ws2812_spi_pixel_encoder
// Converts a direct RGB or color-wheel pixel into 12 SPI bytes, GRB order,
// MSB first, each color bit as a 4-bit symbol; flags the final byte.
// ----------------------------------------------------------------------------
module ws2812_spi_pixel_encoder (
    input  logic        clk,
    input  logic        rst_n,
    wspe_pix_if.sink    pixel,
    wspe_spi_if.source  spi
);

    localparam logic [wspe_pkg::CNT_W-1:0] LAST_IDX = wspe_pkg::CNT_W'(wspe_pkg::NUM_BYTES - 1);

    wspe_pkg::pixel_t               pix_reg,       pix_next;
    logic                           pix_valid_reg, pix_valid_next;
    logic [wspe_pkg::CNT_W-1:0]     cnt_reg,       cnt_next;
    logic [7:0]                     byte_reg,      byte_next;
    logic                           last_reg,      last_next;
    logic                           out_valid_reg, out_valid_next;

    logic                           load_out;
    logic                           accept;
    logic                           cnt_last;
    logic [wspe_pkg::IDX_W-1:0]     pair_lsb;
    wspe_pkg::pixel_t               in_grb;

    assign cnt_last = (cnt_reg == LAST_IDX);
    assign load_out = pix_valid_reg && (!out_valid_reg || spi.ready);
    assign pixel.ready = !pix_valid_reg || (load_out && cnt_last);
    assign accept = pixel.valid && pixel.ready;

    assign pair_lsb = wspe_pkg::IDX_W'(wspe_pkg::PIX_W - 2)
                    - wspe_pkg::IDX_W'({cnt_reg, 1'b0});

    always_comb
    begin
        if (pixel.mode == wspe_pkg::MODE_WHEEL)
        begin
            in_grb = wspe_pkg::wheel_grb(pixel.wheel_pos);
        end
        else
        begin
            in_grb = {pixel.green, pixel.red, pixel.blue};
        end
    end

    always_comb
    begin
        pix_next       = pix_reg;
        pix_valid_next = pix_valid_reg;
        cnt_next       = cnt_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        if (spi.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load_out)
        begin
            byte_next      = wspe_pkg::encode_pair(pix_reg[pair_lsb +: 2]);
            last_next      = cnt_last;
            out_valid_next = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
            if (cnt_last)
            begin
                pix_valid_next = 1'b0;
            end
        end

        if (accept)
        begin
            pix_next       = in_grb;
            pix_valid_next = 1'b1;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg  <= pix_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign spi.valid    = out_valid_reg;
    assign spi.spi_byte = byte_reg;
    assign spi.last     = last_reg;

`ifndef NO_ASSERTIONS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg |-> (cnt_reg <= LAST_IDX))
        else $error("byte counter out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (pix_valid_reg && (cnt_reg == '0)))
        else $error("accepted pixel not loaded at byte zero");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (spi.valid && (spi.last == $past(cnt_last))))
        else $error("last flag does not match byte counter");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid_reg |-> pixel.ready)
        else $error("idle encoder not ready for a pixel");
`endif

endmodule

// ===== verif/ws2812_symbol_checker.sv =====
// ----------------------------------------------------------------------------
// ws2812_symbol_checker
// Watches the pixel and SPI channels of the encoder. Every accepted pixel is
// expanded into its twelve symbol bytes in G, R, B order. Every accepted SPI
// byte is checked, byte value and last flag, against the oldest of them.
// ----------------------------------------------------------------------------
module ws2812_symbol_checker (
    input  logic clk,
    input  logic rst_n,
    wspe_pix_if  pixel,
    wspe_spi_if  spi,
    output int   errors,
    output int   pending,
    output int   pixels_seen,
    output int   bytes_checked
);

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       last;
    } spi_txn_t;

    spi_txn_t symbol_bytes_q[$];

    // Color of one pixel packed as {green, red, blue}.
    function automatic logic [23:0] grb_color_of(input wspe_pkg::mode_t m,
                                                 input logic [7:0] r,
                                                 input logic [7:0] g, input logic [7:0] b,
                                                 input logic [7:0] pos);
        int unsigned p;
        int unsigned q;
        logic [7:0]  rise;
        logic [7:0]  fall;
        if (m == wspe_pkg::MODE_DIRECT)
        begin
            return {g, r, b};
        end
        p = pos;
        if (p < wspe_pkg::WHEEL_SEG1)
        begin
            q = p;
        end
        else if (p < wspe_pkg::WHEEL_SEG2)
        begin
            q = p - wspe_pkg::WHEEL_SEG1;
        end
        else
        begin
            q = p - wspe_pkg::WHEEL_SEG2;
        end
        rise = 8'(3 * q);
        fall = 8'(255 - 3 * q);
        if (p < wspe_pkg::WHEEL_SEG1)
        begin
            return {fall, rise, 8'h00};
        end
        else if (p < wspe_pkg::WHEEL_SEG2)
        begin
            return {8'h00, fall, rise};
        end
        return {rise, 8'h00, fall};
    endfunction

    task automatic queue_symbol_bytes(input logic [23:0] grb);
        logic [7:0] color;
        int         hi;
        spi_txn_t   txn;
        for (int k = 0; k < wspe_pkg::NUM_BYTES; k++)
        begin
            color = grb[23 - 8 * (k / 4) -: 8];
            hi = 7 - 2 * (k % 4);
            txn.spi_byte = (color[hi] ? wspe_pkg::SYM_ONE_HI : wspe_pkg::SYM_ZERO_HI)
                         | (color[hi - 1] ? wspe_pkg::SYM_ONE_LO : wspe_pkg::SYM_ZERO_LO);
            txn.last = (k == wspe_pkg::NUM_BYTES - 1);
            symbol_bytes_q.push_back(txn);
        end
    endtask

    always @(posedge clk)
    begin : watch
        spi_txn_t head;
        int       err_inc;
        int       byte_inc;
        err_inc = 0;
        byte_inc = 0;
        if (!rst_n)
        begin
            symbol_bytes_q.delete();
            errors <= 0;
            pending <= 0;
            pixels_seen <= 0;
            bytes_checked <= 0;
        end
        else
        begin
            // output side first: a byte never belongs to a pixel of the same edge
            if (spi.valid && spi.ready)
            begin
                byte_inc = 1;
                if (symbol_bytes_q.size() == 0)
                begin
                    $display("%0t: unexpected SPI transaction: byte %02h last %0b",
                             $time, spi.spi_byte, spi.last);
                    err_inc++;
                end
                else
                begin
                    head = symbol_bytes_q.pop_front();
                    if (spi.spi_byte !== head.spi_byte)
                    begin
                        $display("%0t: spi_byte mismatch: expected %02h, actual %02h",
                                 $time, head.spi_byte, spi.spi_byte);
                        err_inc++;
                    end
                    if (spi.last !== head.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, head.last, spi.last);
                        err_inc++;
                    end
                end
            end
            if (pixel.valid && pixel.ready)
            begin
                queue_symbol_bytes(grb_color_of(wspe_pkg::mode_t'(pixel.mode), pixel.red,
                                                pixel.green, pixel.blue, pixel.wheel_pos));
                pixels_seen <= pixels_seen + 1;
            end
            errors <= errors + err_inc;
            bytes_checked <= bytes_checked + byte_inc;
            pending <= symbol_bytes_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Pixel stimulus for the WS2812 SPI encoder: directed corner pixels, then
// random direct and wheel pixels under four sender/receiver pacing mixes.
// Checking is done by ws2812_symbol_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int pixels_seen;
    int bytes_checked;

    int src_idle_pct;
    int sink_stall_pct;
    int pixels_sent;
    int wheel_sent;

    wspe_pix_if pix_ch();
    wspe_spi_if spi_ch();

    ws2812_spi_pixel_encoder dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pix_ch),
        .spi   (spi_ch)
    );

    ws2812_symbol_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (pix_ch),
        .spi           (spi_ch),
        .errors        (errors),
        .pending       (pending),
        .pixels_seen   (pixels_seen),
        .bytes_checked (bytes_checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        spi_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic send_pixel(input wspe_pkg::mode_t m, input logic [7:0] r,
                              input logic [7:0] g,
                              input logic [7:0] b, input logic [7:0] pos);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid     <= 1'b1;
        pix_ch.mode      <= m;
        pix_ch.red       <= r;
        pix_ch.green     <= g;
        pix_ch.blue      <= b;
        pix_ch.wheel_pos <= pos;
        @(posedge clk);
        while (!pix_ch.ready)
        begin
            @(posedge clk);
        end
        pixels_sent++;
        if (m == wspe_pkg::MODE_WHEEL)
        begin
            wheel_sent++;
        end
    endtask

    task automatic send_random_pixel();
        wspe_pkg::mode_t m;
        m = wspe_pkg::mode_t'($urandom_range(1));
        send_pixel(m, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    initial
    begin
        int idle_mix[4][2];
        idle_mix = '{'{0, 0}, '{86, 0}, '{0, 86}, '{31, 31}};
        pixels_sent = 0;
        wheel_sent = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n = 1'b0;
        pix_ch.valid     <= 1'b0;
        pix_ch.mode      <= wspe_pkg::MODE_DIRECT;
        pix_ch.red       <= 8'h00;
        pix_ch.green     <= 8'h00;
        pix_ch.blue      <= 8'h00;
        pix_ch.wheel_pos <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // direct pixels: extremes, alternating and single-bit patterns
        send_pixel(wspe_pkg::MODE_DIRECT, 8'h00, 8'h00, 8'h00, 8'($urandom_range(255)));
        send_pixel(wspe_pkg::MODE_DIRECT, 8'hFF, 8'hFF, 8'hFF, 8'($urandom_range(255)));
        send_pixel(wspe_pkg::MODE_DIRECT, 8'hAA, 8'h55, 8'hA5, 8'hFF);
        send_pixel(wspe_pkg::MODE_DIRECT, 8'h55, 8'hAA, 8'h5A, 8'h00);
        send_pixel(wspe_pkg::MODE_DIRECT, 8'h80, 8'h01, 8'h00, 8'h80);
        send_pixel(wspe_pkg::MODE_DIRECT, 8'h00, 8'h80, 8'h01, 8'h01);
        send_pixel(wspe_pkg::MODE_DIRECT, 8'h01, 8'h00, 8'h80, 8'h55);
        // wheel pixels: segment edges and mid-segment positions, color bytes ignored
        send_pixel(wspe_pkg::MODE_WHEEL, 8'h00, 8'h00, 8'h00, 8'd0);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'hFF, 8'hFF, 8'hFF, 8'd84);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'h12, 8'h34, 8'h56, 8'd85);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'hFF, 8'h00, 8'hFF, 8'd169);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'h00, 8'hFF, 8'h00, 8'd170);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'hAA, 8'hAA, 8'hAA, 8'd255);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'h55, 8'h55, 8'h55, 8'd128);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'd42);
        send_pixel(wspe_pkg::MODE_WHEEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'd200);

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct = idle_mix[ph][0];
            sink_stall_pct = idle_mix[ph][1];
            repeat (91)
            begin
                send_random_pixel();
            end
        end
        pix_ch.valid <= 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        while (pending != 0 || pixels_seen != pixels_sent)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d pixels (%0d in wheel mode), %0d SPI bytes checked,",
                 pixels_sent, wheel_sent, bytes_checked);
        $display("under free-running, slow-sender, slow-receiver and mixed pacing.");
        if (errors == 0 && pending == 0)
        begin
            $display("ws2812_spi_pixel_encoder test passed");
        end
        else
        begin
            $display("ws2812_spi_pixel_encoder test failed");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d SPI bytes outstanding", pending);
        $display("ws2812_spi_pixel_encoder test failed");
        $finish;
    end

endmodule
